// File: rtl/core/fbfla_pkg.sv
package fbfla_pkg;

  // Pool geometry
  localparam int unsigned NUM_BLOCKS = 64;
  localparam int unsigned AddrW      = 6;  // addresses one block
  localparam int unsigned IdxW       = 7;  // block index or end marker
  localparam int unsigned SizeW      = 16;
  localparam int unsigned CountW     = 7;

  localparam logic [IdxW-1:0]   EndMarker     = IdxW'(NUM_BLOCKS);
  localparam logic [CountW-1:0] CountFull     = CountW'(NUM_BLOCKS);
  localparam logic [SizeW-1:0]  BlockSizeRst  = SizeW'(64);

  // Operation codes
  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  // Status codes
  localparam logic [1:0] StatOk        = 2'd0;
  localparam logic [1:0] StatExhausted = 2'd1;
  localparam logic [1:0] StatTooLarge  = 2'd2;
  localparam logic [1:0] StatBadIndex  = 2'd3;

  // Request from the controller to the link store
  typedef struct packed {
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [IdxW-1:0]  wr_link;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
  } link_req_t;

endpackage

// File: rtl/core/fixed_block_free_list_allocator_unit.sv
// Pool allocator for 64 equal blocks, kept as a last-in first-out free list
// of block indices. Each input word is an allocate (pop the list head and
// grant it) or a free (push the given index as new head); each gives exactly
// one result word with granted index, status and free count. A request whose
// size is above block_size is refused with status 2, an allocate on an empty
// list gives status 1, a free of an index of 64 or more gives status 3; in
// all those cases the state is left as it was. Double frees are not caught.
// A free or any refused request leaves the block ready at once; a granted
// allocate passes through StPop, as the link of the popped block comes out of
// the registered link memory and must land in the head register first.
// The result word sits in an output register, so the next request is taken
// while it waits, as long as that register frees up in the same cycle.
// No clearing pass is needed after reset: per-entry valid flags supply the
// reset links. The user must write block_size only while idle (not enforced).
module fixed_block_free_list_allocator_unit import fbfla_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,

  // configuration
  input  logic              cfg_we_i,
  input  logic [SizeW-1:0]  cfg_wdata_i,

  // request channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  logic [SizeW-1:0]  req_size_i,
  input  logic [IdxW-1:0]   block_index_i,

  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [AddrW-1:0]  granted_index_o,
  output logic [1:0]        status_o,
  output logic [CountW-1:0] free_count_o
);

  localparam logic StIdle = 1'b0;  // ready for a request
  localparam logic StPop  = 1'b1;  // link of popped head arriving

  logic              state_q, state_d;
  logic [SizeW-1:0]  block_size_q;
  logic [IdxW-1:0]   head_q, head_d;
  logic [CountW-1:0] free_total_q, free_total_d;

  logic              out_valid_q;
  logic [AddrW-1:0]  granted_q, granted_d;
  logic [1:0]        status_q, status_d;

  logic              accept;
  logic              size_bad;
  logic              list_empty;
  logic              index_bad;
  logic              do_pop;
  logic              do_push;

  link_req_t         link_req;
  logic [IdxW-1:0]   next_link;

  // Take a request only while idle and with room in the output register.
  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign size_bad   = req_size_i > block_size_q;
  assign list_empty = head_q >= EndMarker;
  assign index_bad  = block_index_i >= EndMarker;

  assign do_pop  = accept && !size_bad && (func_i == FuncAlloc) && !list_empty;
  assign do_push = accept && !size_bad && (func_i == FuncFree) && !index_bad;

  // Pop reads the head's link; push links the freed block to the old head.
  always_comb begin
    link_req         = '0;
    link_req.rd_en   = do_pop;
    link_req.rd_addr = head_q[AddrW-1:0];
    link_req.wr_en   = do_push;
    link_req.wr_addr = block_index_i[AddrW-1:0];
    link_req.wr_link = head_q;
  end

  fbfla_link_store u_link_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (link_req),
    .link_o (next_link)
  );

  // Decide status, grant and the new free count for an accepted word.
  always_comb begin
    granted_d    = '0;
    status_d     = StatOk;
    free_total_d = free_total_q;
    if (size_bad) begin
      status_d = StatTooLarge;
    end else if (func_i == FuncAlloc) begin
      if (list_empty) begin
        status_d = StatExhausted;
      end else begin
        granted_d = head_q[AddrW-1:0];
        if (free_total_q != '0) begin
          free_total_d = free_total_q - 1'b1;
        end
      end
    end else begin
      if (index_bad) begin
        status_d = StatBadIndex;
      end else if (free_total_q < CountFull) begin
        free_total_d = free_total_q + 1'b1;
      end
    end
  end

  // Head update: push takes the freed index now, pop waits for the link.
  always_comb begin
    head_d  = head_q;
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (do_push) begin
          head_d = block_index_i;
        end
        if (do_pop) begin
          state_d = StPop;
        end
      end
      StPop: begin
        head_d  = next_link;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      head_q       <= '0;
      free_total_q <= CountFull;
      block_size_q <= BlockSizeRst;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      if (cfg_we_i) begin
        block_size_q <= cfg_wdata_i;
      end
      if (accept) begin
        free_total_q <= free_total_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  // Hold the result word until taken.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      granted_q <= granted_d;
      status_q  <= status_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_index_o = granted_q;
  assign status_o        = status_q;
  assign free_count_o    = free_total_q;

endmodule

// File: rtl/core/fbfla_ram.sv
module fbfla_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/fbfla_link_store.sv
module fbfla_link_store import fbfla_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  link_req_t       req_i,
  output logic [IdxW-1:0] link_o
);

  logic [NUM_BLOCKS-1:0] written_q;
  logic                  rd_written_q;
  logic [IdxW-1:0]       rd_dflt_q;
  logic [IdxW-1:0]       ram_rdata;

  fbfla_ram #(
    .Width (IdxW),
    .Depth (NUM_BLOCKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.wr_en),
    .waddr_i (req_i.wr_addr),
    .wdata_i (req_i.wr_link),
    .re_i    (req_i.rd_en),
    .raddr_i (req_i.rd_addr),
    .rdata_o (ram_rdata)
  );

  // An entry never written holds its reset link, index plus one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (req_i.wr_en) begin
      written_q[req_i.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_written_q <= written_q[req_i.rd_addr];
      rd_dflt_q    <= IdxW'({1'b0, req_i.rd_addr} + 1'b1);
    end
  end

  assign link_o = rd_written_q ? ram_rdata : rd_dflt_q;

endmodule

// File: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fbfla_pkg::*;

  // Request word as queued for the driver. from_live asks the driver to free
  // a block that is currently handed out, picked when the word is presented.
  typedef struct {
    logic             func;
    logic [SizeW-1:0] req_size;
    logic [IdxW-1:0]  block_index;
    bit               from_live;
  } pool_req_t;

  typedef struct {
    logic [AddrW-1:0]  granted;
    logic [1:0]        status;
    logic [CountW-1:0] free_count;
  } pool_resp_t;

  // Cycles with no handshake on either side before the run is called hung.
  // Even a 55% stall on either side seldom comes near this limit.
  localparam int QuietLimit = 1000;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [SizeW-1:0]  cfg_wdata_i   = '0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic              func_i        = FuncAlloc;
  logic [SizeW-1:0]  req_size_i    = '0;
  logic [IdxW-1:0]   block_index_i = '0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic [AddrW-1:0]  granted_index_o;
  logic [1:0]        status_o;
  logic [CountW-1:0] free_count_o;

  fixed_block_free_list_allocator_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .req_size_i     (req_size_i),
    .block_index_i  (block_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .granted_index_o(granted_index_o),
    .status_o       (status_o),
    .free_count_o   (free_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the pool: link store, list head, free count, block size.
  logic [IdxW-1:0]   link_mem [NUM_BLOCKS];
  logic [IdxW-1:0]   free_head;
  logic [CountW-1:0] free_blocks;
  logic [SizeW-1:0]  blk_bytes;
  int                live_q[$];      // blocks handed out and not yet freed

  pool_req_t   pending_q[$];
  pool_resp_t  awaited_q[$];
  pool_req_t   cur_req;
  bit          req_held = 1'b0;      // a word is on the request port
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int          err_count = 0;
  int          quiet_cycles = 0;

  task automatic note_mismatch(input string what);
    $display("tb: mismatch at %0t: %s", $time, what);
    err_count++;
  endtask

  // Apply one accepted request to the shadow pool and queue its result.
  task automatic pool_apply(input pool_req_t r);
    pool_resp_t       res;
    logic [AddrW-1:0] slot;
    res.granted = '0;
    res.status  = StatOk;
    if (r.req_size > blk_bytes) begin
      res.status = StatTooLarge;
    end else if (r.func == FuncAlloc) begin
      if (free_head >= EndMarker) begin
        res.status = StatExhausted;
      end else begin
        slot        = free_head[AddrW-1:0];
        res.granted = slot;
        free_head   = link_mem[slot];
        if (free_blocks != '0) free_blocks--;
        live_q.push_back(int'(slot));
      end
    end else if (r.block_index >= EndMarker) begin
      res.status = StatBadIndex;
    end else begin
      // push back as new head; a double free is taken as is
      slot           = r.block_index[AddrW-1:0];
      link_mem[slot] = free_head;
      free_head      = r.block_index;
      if (free_blocks < CountFull) free_blocks++;
      for (int k = 0; k < live_q.size(); k++) begin
        if (live_q[k] == int'(slot)) begin
          live_q.delete(k);
          break;
        end
      end
    end
    res.free_count = free_blocks;
    awaited_q.push_back(res);
  endtask

  function automatic logic [SizeW-1:0] fit_size();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return blk_bytes;
    return SizeW'($urandom_range(0, int'(blk_bytes)));
  endfunction

  // Mostly well-formed requests; some oversize and out-of-range ones. In a
  // noisy phase half the frees name any index, double frees included.
  function automatic pool_req_t rand_req(input int unsigned alloc_pct, input bit noisy);
    pool_req_t   r;
    int unsigned roll;
    r.func        = ($urandom_range(0, 99) < alloc_pct) ? FuncAlloc : FuncFree;
    r.req_size    = fit_size();
    r.block_index = IdxW'($urandom_range(0, 2**IdxW - 1));
    r.from_live   = 1'b0;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      if (blk_bytes != '1)
        r.req_size = SizeW'($urandom_range(int'(blk_bytes) + 1, 2**SizeW - 1));
    end else if (r.func == FuncFree) begin
      if (roll < 12) r.block_index = IdxW'($urandom_range(NUM_BLOCKS, 2**IdxW - 1));
      else if (!noisy || roll < 50) r.from_live = 1'b1;
    end
    return r;
  endfunction

  task automatic push_req(input logic f, input logic [SizeW-1:0] sz,
                          input logic [IdxW-1:0] idx, input bit live);
    pool_req_t r;
    r.func        = f;
    r.req_size    = sz;
    r.block_index = idx;
    r.from_live   = live;
    pending_q.push_back(r);
  endtask

  // Bursts that lean toward allocate, toward free, or neither, so the list
  // runs dry and fills up again within a phase.
  task automatic gen_phase(input int n, input bit noisy);
    int          made;
    int          len;
    int unsigned kind;
    int unsigned alloc_pct;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        alloc_pct = 90;
        len       = $urandom_range(10, 70);
      end else if (kind < 6) begin
        alloc_pct = 10;
        len       = $urandom_range(10, 70);
      end else begin
        alloc_pct = 50;
        len       = $urandom_range(5, 30);
      end
      if (len > n - made) len = n - made;
      repeat (len) pending_q.push_back(rand_req(alloc_pct, noisy));
      made += len;
    end
  endtask

  // Hold until every queued word is in and every result is out, then let
  // the block settle.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || req_held || awaited_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_block_size(input logic [SizeW-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    blk_bytes    = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Driver: retire the word on the port when it is taken, then present the
  // next one or idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pool_apply(cur_req);
        req_held = 1'b0;
      end
      if (!req_held) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_req = pending_q.pop_front();
          if (cur_req.from_live) begin
            // nothing handed out: turn the free into an allocate
            if (live_q.size() != 0)
              cur_req.block_index = IdxW'(live_q[$urandom_range(0, live_q.size() - 1)]);
            else
              cur_req.func = FuncAlloc;
          end
          req_held       = 1'b1;
          in_valid_i    <= 1'b1;
          func_i        <= cur_req.func;
          req_size_i    <= cur_req.req_size;
          block_index_i <= cur_req.block_index;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result word with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    pool_resp_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_q.size() == 0) begin
          note_mismatch("result word with nothing awaited");
        end else begin
          want = awaited_q.pop_front();
          if (granted_index_o !== want.granted)
            note_mismatch($sformatf("granted_index %0d, want %0d",
                                    granted_index_o, want.granted));
          if (status_o !== want.status)
            note_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
          if (free_count_o !== want.free_count)
            note_mismatch($sformatf("free_count %0d, want %0d",
                                    free_count_o, want.free_count));
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < NUM_BLOCKS; i++) link_mem[i] = IdxW'(i + 1);
    free_head      = '0;
    free_blocks    = CountFull;
    blk_bytes      = BlockSizeRst;
    send_idle_pct  = 10;
    recv_stall_pct = 55;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words at the reset block size of 64.
    push_req(FuncAlloc, 16'd0,     7'd127, 1'b0);  // index ignored on allocate
    push_req(FuncAlloc, 16'd64,    7'd0,   1'b0);  // size equal to block size
    push_req(FuncAlloc, 16'd65,    7'd0,   1'b0);  // one byte over
    push_req(FuncAlloc, 16'hFFFF,  7'd0,   1'b0);
    push_req(FuncFree,  16'hFFFF,  7'd0,   1'b0);  // size check on free too
    push_req(FuncFree,  16'd65,    7'd127, 1'b0);  // size check ahead of index
    push_req(FuncFree,  16'd0,     7'd64,  1'b0);  // first out-of-range index
    push_req(FuncFree,  16'd64,    7'd127, 1'b0);
    push_req(FuncFree,  16'd0,     7'd0,   1'b0);  // push block 0 back
    push_req(FuncAlloc, 16'd1,     7'd85,  1'b0);  // last in, first out
    push_req(FuncAlloc, 16'd32,    7'd42,  1'b0);
    push_req(FuncFree,  16'd8,     7'd1,   1'b0);
    push_req(FuncFree,  16'd0,     7'd0,   1'b1);
    push_req(FuncFree,  16'd0,     7'd0,   1'b1);  // pool full again
    wait_drained();

    // Smallest block size; run the pool dry past exhaustion and refill it.
    write_block_size(16'd8);
    repeat (66) push_req(FuncAlloc, fit_size(), IdxW'($urandom_range(0, 127)), 1'b0);
    repeat (66) push_req(FuncFree, fit_size(), '0, 1'b1);
    gen_phase(30, 1'b0);
    wait_drained();

    write_block_size(16'hFFFF);
    gen_phase(70, 1'b0);
    wait_drained();

    send_idle_pct  = 55;
    recv_stall_pct = 10;
    write_block_size(SizeW'($urandom_range(8, 65535)));
    gen_phase(70, 1'b0);
    wait_drained();

    write_block_size(SizeW'($urandom_range(8, 300)));
    gen_phase(70, 1'b0);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_block_size(BlockSizeRst);
    gen_phase(70, 1'b0);
    wait_drained();

    // Double frees can leave a cycle in the list, so they come last.
    write_block_size(SizeW'($urandom_range(8, 2000)));
    gen_phase(70, 1'b1);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (err_count == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
